// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the RTL, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ffa_pkg.sv -----
// ---------------------------------------------------------------------------
// ffa_pkg
// Types, widths and feature codes of the flow feature aggregator.
// ---------------------------------------------------------------------------
package ffa_pkg;

    localparam int MEAN_IN_W   = 24;
    localparam int MEAN_SUM_W  = 40;
    localparam int PKT_IN_W    = 32;
    localparam int PKT_TOT_W   = 48;
    localparam int BYTE_IN_W   = 40;
    localparam int BYTE_TOT_W  = 56;
    localparam int DUR_IN_W    = 32;
    localparam int DUR_TOT_W   = 48;
    localparam int ACK_IN_W    = 32;
    localparam int ACK_TOT_W   = 48;
    localparam int CODE_W      = 4;
    localparam int VALUE_W     = 64;
    localparam int BYTE_SUM_W  = BYTE_TOT_W + 1;
    localparam int PKT_SUM_W   = PKT_TOT_W + 1;
    localparam int QUOT_EXT_W  = 80;

    localparam logic [CODE_W-1:0] FEAT_MAX       = 4'd0;
    localparam logic [CODE_W-1:0] FEAT_MIN       = 4'd1;
    localparam logic [CODE_W-1:0] FEAT_MEAN      = 4'd2;
    localparam logic [CODE_W-1:0] FEAT_FWD_MEAN  = 4'd3;
    localparam logic [CODE_W-1:0] FEAT_BWD_MEAN  = 4'd4;
    localparam logic [CODE_W-1:0] FEAT_DURATION  = 4'd5;
    localparam logic [CODE_W-1:0] FEAT_FWD_PKTS  = 4'd6;
    localparam logic [CODE_W-1:0] FEAT_BWD_PKTS  = 4'd7;
    localparam logic [CODE_W-1:0] FEAT_FWD_BYTES = 4'd8;
    localparam logic [CODE_W-1:0] FEAT_BWD_BYTES = 4'd9;
    localparam logic [CODE_W-1:0] FEAT_BYTE_RATE = 4'd10;
    localparam logic [CODE_W-1:0] FEAT_PKT_RATE  = 4'd11;
    localparam logic [CODE_W-1:0] FEAT_ACK       = 4'd12;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EMIT = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic needs_divide(input logic [CODE_W-1:0] code);
        logic result;
        unique case (code)
            FEAT_MEAN, FEAT_FWD_MEAN, FEAT_BWD_MEAN,
            FEAT_BYTE_RATE, FEAT_PKT_RATE: result = 1'b1;
            default:                       result = 1'b0;
        endcase
        return result;
    endfunction

endpackage

// ----- src/ffa_divider.sv -----
// ---------------------------------------------------------------------------
// ffa_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ffa_divider #(
    parameter int DIVIDEND_W = 65,
    parameter int DIVISOR_W  = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output logic [DIVIDEND_W-1:0]   quotient,
    output ffa_pkg::div_status_t    status
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg, "divider did not start")
    `ASSERT_SAME(a_done_idle, clk, rst_n, done_reg, !busy_reg && step_reg == '0,
                 "divider done while stepping")

endmodule

// ----- src/flow_feature_aggregator.sv -----
// ---------------------------------------------------------------------------
// flow_feature_aggregator
// Folds per-flow statistic records into running aggregates and emits
// 13 features (code/value pairs) on the record marked last.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one record per item. A record
//   without last_record is folded in when accepted; in_ready stays high, so
//   such records stream at one per cycle.
//   A record with last_record is folded, then in_ready drops while the 13
//   features go out on out_valid/out_ready in code order 0..12, with
//   last_feature set on code 12. Means and rates come from one shared
//   restoring divider that yields one quotient bit per cycle; each of the
//   five divisions yields a quotient of 57 + FRACTION_BITS bits.
//   A stalled receiver holds the result in the output register and stalls
//   the sequence; the record aggregates clear when code 12 is loaded, and
//   in_ready returns while that final item may still wait.
//   Reset clears the aggregates (minimum to all ones) and empties the
//   output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module flow_feature_aggregator #(
    parameter int MAX_RECORDS   = 65536,
    parameter int LENGTH_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [LENGTH_BITS-1:0]              largest_length,
    input  logic [LENGTH_BITS-1:0]              smallest_length,
    input  logic [ffa_pkg::MEAN_IN_W-1:0]       mean_length,
    input  logic [ffa_pkg::MEAN_IN_W-1:0]       forward_mean_length,
    input  logic [ffa_pkg::MEAN_IN_W-1:0]       backward_mean_length,
    input  logic [ffa_pkg::PKT_IN_W-1:0]        forward_packets,
    input  logic [ffa_pkg::PKT_IN_W-1:0]        backward_packets,
    input  logic [ffa_pkg::BYTE_IN_W-1:0]       forward_bytes,
    input  logic [ffa_pkg::BYTE_IN_W-1:0]       backward_bytes,
    input  logic [ffa_pkg::DUR_IN_W-1:0]        duration,
    input  logic [ffa_pkg::ACK_IN_W-1:0]        ack_packets,
    input  logic                                last_record,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ffa_pkg::CODE_W-1:0]          feature_code,
    output logic [ffa_pkg::VALUE_W-1:0]         feature_value,
    output logic                                last_feature
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int DIV_W = ffa_pkg::BYTE_SUM_W + FRACTION_BITS;

    ffa_pkg::state_t state_reg, state_next;
    logic [ffa_pkg::CODE_W-1:0] code_reg, code_next;

    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [LENGTH_BITS-1:0]            max_reg, max_next;
    logic [LENGTH_BITS-1:0]            min_reg, min_next;
    logic [ffa_pkg::MEAN_SUM_W-1:0]    mean_sum_reg, mean_sum_next;
    logic [ffa_pkg::MEAN_SUM_W-1:0]    fmean_sum_reg, fmean_sum_next;
    logic [ffa_pkg::MEAN_SUM_W-1:0]    bmean_sum_reg, bmean_sum_next;
    logic [ffa_pkg::PKT_TOT_W-1:0]     fpkt_reg, fpkt_next;
    logic [ffa_pkg::PKT_TOT_W-1:0]     bpkt_reg, bpkt_next;
    logic [ffa_pkg::BYTE_TOT_W-1:0]    fbyte_reg, fbyte_next;
    logic [ffa_pkg::BYTE_TOT_W-1:0]    bbyte_reg, bbyte_next;
    logic [ffa_pkg::DUR_TOT_W-1:0]     dur_reg, dur_next;
    logic [ffa_pkg::ACK_TOT_W-1:0]     ack_reg, ack_next;

    logic [ffa_pkg::VALUE_W-1:0] div_value_reg, div_value_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ffa_pkg::CODE_W-1:0]  out_code_reg, out_code_next;
    logic [ffa_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic                        out_last_reg, out_last_next;

    logic                        accept;
    logic                        load_out;
    logic                        final_load;
    logic [ffa_pkg::CODE_W-1:0]  code_inc;
    logic                        div_start;
    logic [DIV_W-1:0]            div_dividend;
    logic [ffa_pkg::DUR_TOT_W-1:0] div_divisor;
    logic [DIV_W-1:0]            div_quotient;
    ffa_pkg::div_status_t        div_status;
    logic [ffa_pkg::QUOT_EXT_W-1:0] quot_ext;
    logic [ffa_pkg::BYTE_SUM_W-1:0] byte_sum;
    logic [ffa_pkg::PKT_SUM_W-1:0]  pkt_sum;
    logic [ffa_pkg::VALUE_W-1:0]    feat_value;

    assign in_ready   = (state_reg == ffa_pkg::S_IDLE);
    assign accept     = in_valid && in_ready;
    assign load_out   = (state_reg == ffa_pkg::S_EMIT) && (!out_valid_reg || out_ready);
    assign final_load = load_out && (code_reg == ffa_pkg::FEAT_ACK);
    assign code_inc   = code_reg + ffa_pkg::CODE_W'(1);
    assign div_start  = load_out && !final_load && ffa_pkg::needs_divide(code_inc);

    assign byte_sum = {1'b0, fbyte_reg} + {1'b0, bbyte_reg};
    assign pkt_sum  = {1'b0, fpkt_reg} + {1'b0, bpkt_reg};
    assign quot_ext = ffa_pkg::QUOT_EXT_W'(div_quotient);

    always_comb
    begin
        div_dividend = DIV_W'(mean_sum_reg);
        div_divisor  = ffa_pkg::DUR_TOT_W'(count_reg);
        unique case (code_inc)
            ffa_pkg::FEAT_FWD_MEAN: div_dividend = DIV_W'(fmean_sum_reg);
            ffa_pkg::FEAT_BWD_MEAN: div_dividend = DIV_W'(bmean_sum_reg);
            ffa_pkg::FEAT_BYTE_RATE:
            begin
                div_dividend = DIV_W'(byte_sum) << FRACTION_BITS;
                div_divisor  = dur_reg;
            end
            ffa_pkg::FEAT_PKT_RATE:
            begin
                div_dividend = DIV_W'(pkt_sum) << FRACTION_BITS;
                div_divisor  = dur_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        unique case (code_reg)
            ffa_pkg::FEAT_MAX:       feat_value = ffa_pkg::VALUE_W'(max_reg);
            ffa_pkg::FEAT_MIN:       feat_value = ffa_pkg::VALUE_W'(min_reg);
            ffa_pkg::FEAT_DURATION:  feat_value = ffa_pkg::VALUE_W'(dur_reg);
            ffa_pkg::FEAT_FWD_PKTS:  feat_value = ffa_pkg::VALUE_W'(fpkt_reg);
            ffa_pkg::FEAT_BWD_PKTS:  feat_value = ffa_pkg::VALUE_W'(bpkt_reg);
            ffa_pkg::FEAT_FWD_BYTES: feat_value = ffa_pkg::VALUE_W'(fbyte_reg);
            ffa_pkg::FEAT_BWD_BYTES: feat_value = ffa_pkg::VALUE_W'(bbyte_reg);
            ffa_pkg::FEAT_ACK:       feat_value = ffa_pkg::VALUE_W'(ack_reg);
            default:                 feat_value = div_value_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        div_value_next = div_value_reg;
        unique case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (accept && last_record)
                begin
                    code_next  = ffa_pkg::FEAT_MAX;
                    state_next = ffa_pkg::S_EMIT;
                end
            end
            ffa_pkg::S_EMIT:
            begin
                if (final_load)
                begin
                    state_next = ffa_pkg::S_IDLE;
                end
                else if (load_out)
                begin
                    code_next = code_inc;
                    if (div_start)
                    begin
                        state_next = ffa_pkg::S_DIV;
                    end
                end
            end
            ffa_pkg::S_DIV:
            begin
                if (div_status.done)
                begin
                    priority if ((code_reg == ffa_pkg::FEAT_BYTE_RATE
                                  || code_reg == ffa_pkg::FEAT_PKT_RATE)
                                 && (dur_reg == '0
                                     || quot_ext[ffa_pkg::QUOT_EXT_W-1:ffa_pkg::VALUE_W] != '0))
                    begin
                        div_value_next = '1;
                    end
                    else
                    begin
                        div_value_next = quot_ext[ffa_pkg::VALUE_W-1:0];
                    end
                    state_next = ffa_pkg::S_EMIT;
                end
            end
            default: state_next = ffa_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        mean_sum_next  = mean_sum_reg;
        fmean_sum_next = fmean_sum_reg;
        bmean_sum_next = bmean_sum_reg;
        fpkt_next      = fpkt_reg;
        bpkt_next      = bpkt_reg;
        fbyte_next     = fbyte_reg;
        bbyte_next     = bbyte_reg;
        dur_next       = dur_reg;
        ack_next       = ack_reg;
        if (accept)
        begin
            if (count_reg != CNT_W'(MAX_RECORDS))
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (largest_length > max_reg)
            begin
                max_next = largest_length;
            end
            if (smallest_length < min_reg)
            begin
                min_next = smallest_length;
            end
            mean_sum_next  = mean_sum_reg + ffa_pkg::MEAN_SUM_W'(mean_length);
            fmean_sum_next = fmean_sum_reg + ffa_pkg::MEAN_SUM_W'(forward_mean_length);
            bmean_sum_next = bmean_sum_reg + ffa_pkg::MEAN_SUM_W'(backward_mean_length);
            fpkt_next      = fpkt_reg + ffa_pkg::PKT_TOT_W'(forward_packets);
            bpkt_next      = bpkt_reg + ffa_pkg::PKT_TOT_W'(backward_packets);
            fbyte_next     = fbyte_reg + ffa_pkg::BYTE_TOT_W'(forward_bytes);
            bbyte_next     = bbyte_reg + ffa_pkg::BYTE_TOT_W'(backward_bytes);
            dur_next       = dur_reg + ffa_pkg::DUR_TOT_W'(duration);
            ack_next       = ack_reg + ffa_pkg::ACK_TOT_W'(ack_packets);
        end
        else if (final_load)
        begin
            count_next     = '0;
            max_next       = '0;
            min_next       = '1;
            mean_sum_next  = '0;
            fmean_sum_next = '0;
            bmean_sum_next = '0;
            fpkt_next      = '0;
            bpkt_next      = '0;
            fbyte_next     = '0;
            bbyte_next     = '0;
            dur_next       = '0;
            ack_next       = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
            out_code_next  = code_reg;
            out_value_next = feat_value;
            out_last_next  = (code_reg == ffa_pkg::FEAT_ACK);
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffa_pkg::S_IDLE;
            code_reg      <= ffa_pkg::FEAT_MAX;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            max_reg       <= '0;
            min_reg       <= '1;
            mean_sum_reg  <= '0;
            fmean_sum_reg <= '0;
            bmean_sum_reg <= '0;
            fpkt_reg      <= '0;
            bpkt_reg      <= '0;
            fbyte_reg     <= '0;
            bbyte_reg     <= '0;
            dur_reg       <= '0;
            ack_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            mean_sum_reg  <= mean_sum_next;
            fmean_sum_reg <= fmean_sum_next;
            bmean_sum_reg <= bmean_sum_next;
            fpkt_reg      <= fpkt_next;
            bpkt_reg      <= bpkt_next;
            fbyte_reg     <= fbyte_next;
            bbyte_reg     <= bbyte_next;
            dur_reg       <= dur_next;
            ack_reg       <= ack_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_value_reg <= div_value_next;
        out_code_reg  <= out_code_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    ffa_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (ffa_pkg::DUR_TOT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign out_valid     = out_valid_reg;
    assign feature_code  = out_code_reg;
    assign feature_value = out_value_reg;
    assign last_feature  = out_last_reg;

    `ASSERT_SAME(a_last_is_ack, clk, rst_n, out_valid_reg && out_last_reg,
                 out_code_reg == ffa_pkg::FEAT_ACK, "last feature on wrong code")
    `ASSERT_SAME(a_div_running, clk, rst_n, state_reg == ffa_pkg::S_DIV,
                 div_status.busy || div_status.done, "waiting on idle divider")
    `ASSERT_SAME(a_start_free, clk, rst_n, div_start, !div_status.busy,
                 "divider started while busy")
    `ASSERT_NEXT(a_clear_after_set, clk, rst_n, final_load,
                 count_reg == '0 && in_ready, "aggregates not cleared after set")

endmodule
